>>> design/two_dimensional_parity_defines.svh
// Assertion helpers for the design files; tdp_emit includes them.
`ifndef TWO_DIMENSIONAL_PARITY_DEFINES_SVH
`define TWO_DIMENSIONAL_PARITY_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define TDP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> design/tdp_pkg.sv
`default_nettype none
package tdp_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W   = $clog2(MAX_COLS + 1);

  localparam int SIZE_W   = 5;
  localparam int POS_W    = 4;
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam logic [SIZE_W-1:0] ROWS_RST = 5'd4;
  localparam logic [SIZE_W-1:0] COLS_RST = 5'd8;

  typedef enum logic [1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1,
    REG_ODD       = 2'd2,
    REG_CHECK     = 2'd3
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ROW    = 2'd0,
    KIND_COL    = 2'd1,
    KIND_CORNER = 2'd2,
    KIND_REPORT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MAT_NONE,
    MAT_ENC,
    MAT_CHK
  } mat_t;

  typedef enum logic [1:0] {
    PH_ROW,
    PH_COL,
    PH_CORNER,
    PH_REPORT
  } phase_t;

  typedef struct packed {
    logic [SIZE_W-1:0] row_count;
    logic [SIZE_W-1:0] col_count;
    logic              odd_parity;
    logic              check_mode;
  } cfg_t;

  // Everything the output sequencer needs for the results of one word.
  typedef struct packed {
    logic                has_row;
    logic [ROW_W-1:0]    row_pos;
    logic                row_par;
    mat_t                mat;
    logic [MAX_COLS-1:0] col_par;
    logic [COL_W-1:0]    last_col;
    logic                corner;
    logic                row_err;
    logic [ROW_W-1:0]    err_row;
    logic                col_err;
    logic [COL_W-1:0]    err_col;
  } job_t;

endpackage
`default_nettype wire

>>> design/tdp_regs.sv
`default_nettype none
module tdp_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tdp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tdp_pkg::DATA_W-1:0] pwdata,
  output logic      [tdp_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output tdp_pkg::cfg_t                  cfg
);
  import tdp_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ROW_COUNT: cfg_nxt.row_count  = pwdata[SIZE_W-1:0];
        REG_COL_COUNT: cfg_nxt.col_count  = pwdata[SIZE_W-1:0];
        REG_ODD:       cfg_nxt.odd_parity = pwdata[0];
        REG_CHECK:     cfg_nxt.check_mode = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW_COUNT: prdata = DATA_W'(cfg_r.row_count);
      REG_COL_COUNT: prdata = DATA_W'(cfg_r.col_count);
      REG_ODD:       prdata = DATA_W'(cfg_r.odd_parity);
      REG_CHECK:     prdata = DATA_W'(cfg_r.check_mode);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count  <= ROWS_RST;
      cfg_r.col_count  <= COLS_RST;
      cfg_r.odd_parity <= 1'b0;
      cfg_r.check_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/tdp_core.sv
`default_nettype none
module tdp_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tdp_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire logic          data_bit,
  output logic               push,
  output tdp_pkg::job_t      job
);
  import tdp_pkg::*;

  logic                row_acc_r, row_acc_nxt;
  logic [MAX_COLS-1:0] col_acc_r, col_acc_nxt;
  logic [ROW_W-1:0]    row_pos_r, row_pos_nxt;
  logic [COL_W-1:0]    col_pos_r, col_pos_nxt;
  logic [MAX_ROWS-1:0] st_row_r, st_row_nxt;
  logic [MAX_COLS-1:0] st_col_r, st_col_nxt;
  logic                bad_vld_r, bad_vld_nxt;
  logic [ROW_W-1:0]    bad_row_r, bad_row_nxt;

  logic [RCNT_W-1:0]   rows;
  logic [CCNT_W-1:0]   cols;
  logic                row_acc_x;
  logic [MAX_COLS-1:0] col_acc_x;
  logic                row_end, mat_end, rpar, mism;
  logic                bad_vld_x;
  logic [ROW_W-1:0]    bad_row_x;
  logic [MAX_COLS-1:0] col_mask, col_par, col_diff;
  logic [COL_W-1:0]    first_col;

  always_comb begin
    if (cfg.row_count == '0)
      rows = RCNT_W'(1);
    else if (32'(cfg.row_count) > MAX_ROWS)
      rows = RCNT_W'(MAX_ROWS);
    else
      rows = RCNT_W'(cfg.row_count);
    if (cfg.col_count == '0)
      cols = CCNT_W'(1);
    else if (32'(cfg.col_count) > MAX_COLS)
      cols = CCNT_W'(MAX_COLS);
    else
      cols = CCNT_W'(cfg.col_count);
  end

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i] = (CCNT_W'(i) < cols);
    end
  end

  assign row_acc_x = row_acc_r ^ data_bit;
  assign col_acc_x = col_acc_r ^ (MAX_COLS'(data_bit) << col_pos_r);
  assign row_end   = ({1'b0, col_pos_r} + CCNT_W'(1)) >= cols;
  assign mat_end   = row_end && (({1'b0, row_pos_r} + RCNT_W'(1)) >= rows);
  assign rpar      = row_acc_x ^ cfg.odd_parity;
  assign mism      = st_row_r[row_pos_r] != rpar;

  // first mismatching row in check mode, held from the row end that finds it
  always_comb begin
    bad_vld_x = bad_vld_r;
    bad_row_x = bad_row_r;
    if (row_end && cfg.check_mode && mism && !bad_vld_r) begin
      bad_vld_x = 1'b1;
      bad_row_x = row_pos_r;
    end
  end

  assign col_par  = col_acc_x ^ {MAX_COLS{cfg.odd_parity}};
  assign col_diff = (col_par ^ st_col_r) & col_mask;

  // lowest set bit of col_diff
  always_comb begin
    first_col = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (col_diff[i]) first_col = COL_W'(i);
    end
  end

  always_comb begin
    job.has_row  = row_end && !cfg.check_mode;
    job.row_pos  = row_pos_r;
    job.row_par  = rpar;
    job.mat      = !mat_end ? MAT_NONE : (cfg.check_mode ? MAT_CHK : MAT_ENC);
    job.col_par  = col_par;
    job.last_col = COL_W'(cols - CCNT_W'(1));
    job.corner   = (^(col_par & col_mask)) ^ cfg.odd_parity;
    job.row_err  = bad_vld_x;
    job.err_row  = bad_vld_x ? bad_row_x : '0;
    job.col_err  = |col_diff;
    job.err_col  = first_col;
  end

  assign push = accept && (job.has_row || mat_end);

  always_comb begin
    row_acc_nxt = row_acc_r;
    col_acc_nxt = col_acc_r;
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    st_row_nxt  = st_row_r;
    st_col_nxt  = st_col_r;
    bad_vld_nxt = bad_vld_r;
    bad_row_nxt = bad_row_r;
    if (accept) begin
      col_acc_nxt = col_acc_x;
      if (!row_end) begin
        row_acc_nxt = row_acc_x;
        col_pos_nxt = col_pos_r + COL_W'(1);
      end else begin
        row_acc_nxt = 1'b0;
        col_pos_nxt = '0;
        if (!cfg.check_mode) st_row_nxt[row_pos_r] = rpar;
        if (!mat_end) begin
          row_pos_nxt = row_pos_r + ROW_W'(1);
          bad_vld_nxt = bad_vld_x;
          bad_row_nxt = bad_row_x;
        end else begin
          if (!cfg.check_mode) st_col_nxt = (st_col_r & ~col_mask) | (col_par & col_mask);
          col_acc_nxt = '0;
          row_pos_nxt = '0;
          bad_vld_nxt = 1'b0;
          bad_row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_acc_r <= 1'b0;
      col_acc_r <= '0;
      row_pos_r <= '0;
      col_pos_r <= '0;
      st_row_r  <= '0;
      st_col_r  <= '0;
      bad_vld_r <= 1'b0;
      bad_row_r <= '0;
    end else begin
      row_acc_r <= row_acc_nxt;
      col_acc_r <= col_acc_nxt;
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      st_row_r  <= st_row_nxt;
      st_col_r  <= st_col_nxt;
      bad_vld_r <= bad_vld_nxt;
      bad_row_r <= bad_row_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/tdp_emit.sv
`default_nettype none
`include "two_dimensional_parity_defines.svh"
module tdp_emit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire tdp_pkg::job_t               job_in,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tdp_pkg::KIND_W-1:0]       out_result_kind,
  output logic [tdp_pkg::POS_W-1:0]        out_position,
  output logic                             out_parity_bit,
  output logic                             out_row_error_found,
  output logic [tdp_pkg::POS_W-1:0]        out_error_row,
  output logic                             out_col_error_found,
  output logic [tdp_pkg::POS_W-1:0]        out_error_col,
  output logic                             out_last_result
);
  import tdp_pkg::*;

  job_t             job_r, job_nxt;
  logic             busy_r, busy_nxt;
  phase_t           phase_r, phase_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             out_fire, last, done;
  kind_t            kind;

  assign out_fire  = busy_r && out_ready;
  assign done      = out_fire && last;
  assign in_ready  = !busy_r || done;
  assign out_valid = busy_r;

  always_comb begin
    last                = 1'b0;
    kind                = KIND_ROW;
    out_position        = '0;
    out_parity_bit      = 1'b0;
    out_row_error_found = 1'b0;
    out_error_row       = '0;
    out_col_error_found = 1'b0;
    out_error_col       = '0;
    unique case (phase_r)
      PH_ROW: begin
        kind           = KIND_ROW;
        last           = job_r.mat == MAT_NONE;
        out_position   = POS_W'(job_r.row_pos);
        out_parity_bit = job_r.row_par;
      end
      PH_COL: begin
        kind           = KIND_COL;
        out_position   = POS_W'(col_r);
        out_parity_bit = job_r.col_par[col_r];
      end
      PH_CORNER: begin
        kind           = KIND_CORNER;
        last           = 1'b1;
        out_parity_bit = job_r.corner;
      end
      PH_REPORT: begin
        kind                = KIND_REPORT;
        last                = 1'b1;
        out_row_error_found = job_r.row_err;
        out_error_row       = POS_W'(job_r.err_row);
        out_col_error_found = job_r.col_err;
        out_error_col       = POS_W'(job_r.err_col);
      end
      default: last = 1'b1;
    endcase
  end

  assign out_result_kind = kind;
  assign out_last_result = last;

  always_comb begin
    job_nxt   = job_r;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    col_nxt   = col_r;
    if (push) begin
      job_nxt  = job_in;
      busy_nxt = 1'b1;
      col_nxt  = '0;
      if (job_in.has_row)
        phase_nxt = PH_ROW;
      else if (job_in.mat == MAT_ENC)
        phase_nxt = PH_COL;
      else
        phase_nxt = PH_REPORT;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (out_fire) begin
      unique case (phase_r)
        PH_ROW: begin
          col_nxt   = '0;
          phase_nxt = (job_r.mat == MAT_ENC) ? PH_COL : PH_REPORT;
        end
        PH_COL: begin
          if (col_r == job_r.last_col)
            phase_nxt = PH_CORNER;
          else
            col_nxt = col_r + COL_W'(1);
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_ROW;
      col_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  `TDP_ASSERT(a_ready_when_empty, !busy_r |-> in_ready, "empty slot must take a word")
  `TDP_ASSERT(a_col_only_enc, busy_r && phase_r == PH_COL |-> job_r.mat == MAT_ENC, "column phase outside encode")
  `TDP_ASSERT(a_col_in_range, busy_r && phase_r == PH_COL |-> col_r <= job_r.last_col, "column index past last column")
  `TDP_ASSERT(a_drain, done && !push |=> !busy_r, "slot not freed after last result")
  `TDP_ASSERT_RST(a_reset_idle, !rst_n |=> !busy_r, "reset must empty the slot")

endmodule
`default_nettype wire

>>> design/two_dimensional_parity.sv
// Two-dimensional parity generator/checker, one matrix bit per input word.
// Latency: a word's first result, if it has any, is offered the cycle after it is accepted.
// Throughput: one word per cycle while each word's results leave as offered; input stalls
// while results wait in the output slot, so an encode matrix end (cols+2 results: row,
// columns, corner) holds the input until its corner result is taken.
// Reset (rst_n, synchronous): accumulators, positions and stored parities clear;
// registers return to 4 rows, 8 columns, even parity, encode mode.
`default_nettype none
module two_dimensional_parity (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tdp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tdp_pkg::DATA_W-1:0] pwdata,
  output logic      [tdp_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_data_bit,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [tdp_pkg::KIND_W-1:0]      out_result_kind,
  output logic [tdp_pkg::POS_W-1:0]       out_position,
  output logic                            out_parity_bit,
  output logic                            out_row_error_found,
  output logic [tdp_pkg::POS_W-1:0]       out_error_row,
  output logic                            out_col_error_found,
  output logic [tdp_pkg::POS_W-1:0]       out_error_col,
  output logic                            out_last_result
);
  import tdp_pkg::*;

  cfg_t cfg;
  job_t job;
  logic push;
  logic accept;

  assign accept = in_valid && in_ready;

  tdp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (accept),
    .data_bit (in_data_bit),
    .push     (push),
    .job      (job)
  );

  tdp_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .job_in              (job),
    .in_ready            (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_position        (out_position),
    .out_parity_bit      (out_parity_bit),
    .out_row_error_found (out_row_error_found),
    .out_error_row       (out_error_row),
    .out_col_error_found (out_col_error_found),
    .out_error_col       (out_error_col),
    .out_last_result     (out_last_result)
  );

endmodule
`default_nettype wire
